### rtl/core/psat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psat_pkg
// Shared types and constants of the polygon separating-axis test block.
// ----------------------------------------------------------------------------
package psat_pkg;

   localparam int MAX_VERTS_DEF = 16;

   localparam int COORD_W = 16;
   localparam int PACK_W  = 2 * COORD_W;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int PROJ_W  = PROD_W + 1;
   localparam int GAP_W   = PROJ_W + 1;
   localparam int DEPTH_W = 32;

   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_EVAL   = 2'd2;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic rd_en;
      logic tag_a;
      logic tag_b;
      logic tag_first;
      logic norm_rd;
      logic norm_b;
      logic gap_calc;
      logic cmp;
      logic first_axis;
      logic out_load;
      logic res_sep;
      logic res_empty;
      logic res_ovf;
   } psat_cmd_type;

endpackage

### rtl/core/psat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psat_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module psat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/psat_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psat_datapath
// Vertex and normal stores, projection pipeline, extreme tracking, gap and
// best-axis registers, and the result register.
// ----------------------------------------------------------------------------
module psat_datapath #(
   parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF
) (
   input  logic                                  clock,
   input  psat_pkg::psat_cmd_type                cmd,
   input  logic [$clog2(MAX_VERTS)-1:0]          wr_addr,
   input  logic [$clog2(MAX_VERTS)-1:0]          rd_addr,
   input  logic [$clog2(MAX_VERTS)-1:0]          norm_addr,
   input  logic signed [psat_pkg::COORD_W-1:0]   point_x,
   input  logic signed [psat_pkg::COORD_W-1:0]   point_y,
   input  logic signed [psat_pkg::COORD_W-1:0]   normal_x,
   input  logic signed [psat_pkg::COORD_W-1:0]   normal_y,
   output logic                                  gap_neg,
   output logic                                  separated,
   output logic [psat_pkg::DEPTH_W-1:0]          depth,
   output logic signed [psat_pkg::COORD_W-1:0]   axis_x,
   output logic signed [psat_pkg::COORD_W-1:0]   axis_y,
   output logic                                  source_polygon,
   output logic                                  empty_res,
   output logic                                  overflowed
);

   import psat_pkg::*;

   logic [PACK_W-1:0] wr_vert;
   logic [PACK_W-1:0] wr_norm;
   logic [PACK_W-1:0] va_rd;
   logic [PACK_W-1:0] vb_rd;
   logic [PACK_W-1:0] na_rd;
   logic [PACK_W-1:0] nb_rd;
   logic [PACK_W-1:0] nrm;

   logic norm_b_ff;
   logic s1_a_ff, s1_b_ff, s1_first_ff;
   logic s2_a_ff, s2_b_ff, s2_first_ff;

   logic signed [PROD_W-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;
   logic signed [PROJ_W-1:0] proj_a, proj_b;
   logic signed [PROJ_W-1:0] max_a_ff, min_a_ff, max_b_ff, min_b_ff;
   logic signed [GAP_W-1:0]  gap_in, gap_ff, best_ff;
   logic [PACK_W-1:0]        best_axis_ff;
   logic                     best_src_ff;
   logic                     best_upd;

   logic                     sep_ff, empty_ff, ovf_ff, src_ff;
   logic [DEPTH_W-1:0]       depth_ff;
   logic [PACK_W-1:0]        axis_ff;

   assign wr_vert = {point_y, point_x};
   assign wr_norm = {normal_y, normal_x};

   psat_ram #(.WIDTH(PACK_W), .DEPTH(MAX_VERTS)) u_verts_a (
      .clock(clock), .wr_en(cmd.wr_a), .wr_addr(wr_addr), .wr_data(wr_vert),
      .rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(va_rd)
   );

   psat_ram #(.WIDTH(PACK_W), .DEPTH(MAX_VERTS)) u_verts_b (
      .clock(clock), .wr_en(cmd.wr_b), .wr_addr(wr_addr), .wr_data(wr_vert),
      .rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(vb_rd)
   );

   psat_ram #(.WIDTH(PACK_W), .DEPTH(MAX_VERTS)) u_norms_a (
      .clock(clock), .wr_en(cmd.wr_a), .wr_addr(wr_addr), .wr_data(wr_norm),
      .rd_en(cmd.norm_rd & ~cmd.norm_b), .rd_addr(norm_addr), .rd_data(na_rd)
   );

   psat_ram #(.WIDTH(PACK_W), .DEPTH(MAX_VERTS)) u_norms_b (
      .clock(clock), .wr_en(cmd.wr_b), .wr_addr(wr_addr), .wr_data(wr_norm),
      .rd_en(cmd.norm_rd & cmd.norm_b), .rd_addr(norm_addr), .rd_data(nb_rd)
   );

   assign nrm = norm_b_ff ? nb_rd : na_rd;

   // projection pipeline: tags, products, then sums into the extremes
   always_ff @(posedge clock) begin
      if (cmd.norm_rd) begin
         norm_b_ff <= cmd.norm_b;
      end
      s1_a_ff     <= cmd.rd_en & cmd.tag_a;
      s1_b_ff     <= cmd.rd_en & cmd.tag_b;
      s1_first_ff <= cmd.rd_en & cmd.tag_first;
      s2_a_ff     <= s1_a_ff;
      s2_b_ff     <= s1_b_ff;
      s2_first_ff <= s1_first_ff;
      pax_ff <= $signed(va_rd[COORD_W-1:0])      * $signed(nrm[COORD_W-1:0]);
      pay_ff <= $signed(va_rd[PACK_W-1:COORD_W]) * $signed(nrm[PACK_W-1:COORD_W]);
      pbx_ff <= $signed(vb_rd[COORD_W-1:0])      * $signed(nrm[COORD_W-1:0]);
      pby_ff <= $signed(vb_rd[PACK_W-1:COORD_W]) * $signed(nrm[PACK_W-1:COORD_W]);
   end

   assign proj_a = PROJ_W'(pax_ff) + PROJ_W'(pay_ff);
   assign proj_b = PROJ_W'(pbx_ff) + PROJ_W'(pby_ff);

   always_ff @(posedge clock) begin
      if (s2_a_ff) begin
         if (s2_first_ff || proj_a > max_a_ff) begin
            max_a_ff <= proj_a;
         end
         if (s2_first_ff || proj_a < min_a_ff) begin
            min_a_ff <= proj_a;
         end
      end
      if (s2_b_ff) begin
         if (s2_first_ff || proj_b > max_b_ff) begin
            max_b_ff <= proj_b;
         end
         if (s2_first_ff || proj_b < min_b_ff) begin
            min_b_ff <= proj_b;
         end
      end
   end

   // gap along the current axis and the running best
   assign gap_in = norm_b_ff ? (GAP_W'(max_b_ff) - GAP_W'(min_a_ff))
                             : (GAP_W'(max_a_ff) - GAP_W'(min_b_ff));
   assign gap_neg  = gap_ff[GAP_W-1];
   assign best_upd = cmd.cmp & ~gap_neg & (cmd.first_axis | (gap_ff < best_ff));

   always_ff @(posedge clock) begin
      if (cmd.gap_calc) begin
         gap_ff <= gap_in;
      end
      if (best_upd) begin
         best_ff      <= gap_ff;
         best_axis_ff <= nrm;
         best_src_ff  <= norm_b_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sep_ff   <= cmd.res_sep;
         empty_ff <= cmd.res_empty;
         ovf_ff   <= cmd.res_ovf;
         if (cmd.res_sep || cmd.res_empty) begin
            depth_ff <= '0;
            axis_ff  <= '0;
            src_ff   <= 1'b0;
         end else begin
            if (best_ff[GAP_W-1:DEPTH_W] != '0) begin
               depth_ff <= '1;
            end else begin
               depth_ff <= best_ff[DEPTH_W-1:0];
            end
            axis_ff <= best_axis_ff;
            src_ff  <= best_src_ff;
         end
      end
   end

   assign separated      = sep_ff;
   assign depth          = depth_ff;
   assign axis_x         = axis_ff[COORD_W-1:0];
   assign axis_y         = axis_ff[PACK_W-1:COORD_W];
   assign source_polygon = src_ff;
   assign empty_res      = empty_ff;
   assign overflowed     = ovf_ff;

endmodule

### rtl/core/psat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psat_ctrl
// Controller: load counts, overflow flag, axis and vertex walk, result
// handshake.
// ----------------------------------------------------------------------------
module psat_ctrl #(
   parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             gap_neg,
   output psat_pkg::psat_cmd_type           cmd,
   output logic [$clog2(MAX_VERTS)-1:0]     wr_addr,
   output logic [$clog2(MAX_VERTS)-1:0]     rd_addr,
   output logic [$clog2(MAX_VERTS)-1:0]     norm_addr
);

   import psat_pkg::*;

   localparam int AW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_VERTS);
   localparam logic [CW-1:0] ONE  = CW'(1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_DR1   = 3'd3;
   localparam logic [2:0] ST_DR2   = 3'd4;
   localparam logic [2:0] ST_GAP   = 3'd5;
   localparam logic [2:0] ST_CMP   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] i_ff, i_in;
   logic          ovf_ff, ovf_in;
   logic          sep_ff, sep_in;
   logic          empty_ff, empty_in;
   logic          on_b_ff, on_b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] nmax;
   logic [CW-1:0] k_next;
   logic [CW-1:0] i_next;
   logic          accept;

   assign nmax    = (count_a_ff > count_b_ff) ? count_a_ff : count_b_ff;
   assign k_next  = k_ff + ONE;
   assign i_next  = i_ff + ONE;
   assign accept  = req_valid & req_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign rd_addr   = i_ff[AW-1:0];
   assign norm_addr = k_ff[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      ovf_in     = ovf_ff;
      sep_in     = sep_ff;
      empty_in   = empty_ff;
      on_b_in    = on_b_ff;
      cmd        = '0;
      wr_addr    = count_a_ff[AW-1:0];
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_kind == KIND_LOAD_A) begin
                  if (count_a_ff != FULL) begin
                     cmd.wr_a   = 1'b1;
                     count_a_in = count_a_ff + ONE;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (req_kind == KIND_LOAD_B) begin
                  wr_addr = count_b_ff[AW-1:0];
                  if (count_b_ff != FULL) begin
                     cmd.wr_b   = 1'b1;
                     count_b_in = count_b_ff + ONE;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (req_kind == KIND_EVAL) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_START: begin
            k_in    = '0;
            i_in    = '0;
            on_b_in = 1'b0;
            priority if (count_a_ff == '0 && count_b_ff == '0) begin
               empty_in = 1'b1;
               sep_in   = 1'b0;
               state_in = ST_DONE;
            end else if (count_a_ff == '0 || count_b_ff == '0) begin
               empty_in = 1'b0;
               sep_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               empty_in = 1'b0;
               sep_in   = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.rd_en     = 1'b1;
            cmd.tag_a     = (i_ff < count_a_ff);
            cmd.tag_b     = (i_ff < count_b_ff);
            cmd.tag_first = (i_ff == '0);
            cmd.norm_rd   = (i_ff == '0);
            cmd.norm_b    = on_b_ff;
            if (i_next == nmax) begin
               state_in = ST_DR1;
            end else begin
               i_in = i_next;
            end
         end
         ST_DR1: begin
            state_in = ST_DR2;
         end
         ST_DR2: begin
            state_in = ST_GAP;
         end
         ST_GAP: begin
            cmd.gap_calc = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp        = 1'b1;
            cmd.first_axis = ~on_b_ff & (k_ff == '0);
            i_in           = '0;
            priority if (gap_neg) begin
               sep_in   = 1'b1;
               state_in = ST_DONE;
            end else if (on_b_ff && k_next == count_b_ff) begin
               state_in = ST_DONE;
            end else if (!on_b_ff && k_next == count_a_ff) begin
               on_b_in  = 1'b1;
               k_in     = '0;
               state_in = ST_WALK;
            end else begin
               k_in     = k_next;
               state_in = ST_WALK;
            end
         end
         ST_DONE: begin
            cmd.res_sep   = sep_ff;
            cmd.res_empty = empty_ff;
            cmd.res_ovf   = ovf_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               count_a_in   = '0;
               count_b_in   = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         ovf_ff       <= 1'b0;
         sep_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         on_b_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         ovf_ff       <= ovf_in;
         sep_ff       <= sep_in;
         empty_ff     <= empty_in;
         on_b_ff      <= on_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/polygon_separating_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_separating_axis_test
// Separating-axis overlap test of two convex polygons held in on-chip stores.
//
// Usage: the req channel carries load and evaluate items. A load of polygon A
// or B appends a vertex with its edge normal, and loads may follow back to
// back. A load into a full store is dropped and flagged. An evaluate walks
// every normal of A then of B; for each axis the vertex stores are read in
// parallel over max(count_a, count_b) vertex addresses through the single
// projection pipeline. It stops early on the first separating axis. The rsp
// channel then carries one result per evaluate from an output register; loads
// give none. While a result waits for rsp_ready the block still takes loads,
// but a further evaluate holds in its final state until the result register
// frees. Evaluate empties both stores and clears the overflow flag. Reset
// empties the stores and clears all control state.
// ----------------------------------------------------------------------------
module polygon_separating_axis_test #(
   parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic signed [psat_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [psat_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [psat_pkg::COORD_W-1:0]  req_normal_x,
   input  logic signed [psat_pkg::COORD_W-1:0]  req_normal_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_separated,
   output logic [psat_pkg::DEPTH_W-1:0]         rsp_depth,
   output logic signed [psat_pkg::COORD_W-1:0]  rsp_axis_x,
   output logic signed [psat_pkg::COORD_W-1:0]  rsp_axis_y,
   output logic                                 rsp_source_polygon,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_overflowed
);

   import psat_pkg::*;

   localparam int AW = $clog2(MAX_VERTS);

   psat_cmd_type cmd;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] norm_addr;
   logic          gap_neg;

   psat_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .gap_neg   (gap_neg),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .norm_addr (norm_addr)
   );

   psat_datapath #(.MAX_VERTS(MAX_VERTS)) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .norm_addr      (norm_addr),
      .point_x        (req_point_x),
      .point_y        (req_point_y),
      .normal_x       (req_normal_x),
      .normal_y       (req_normal_y),
      .gap_neg        (gap_neg),
      .separated      (rsp_separated),
      .depth          (rsp_depth),
      .axis_x         (rsp_axis_x),
      .axis_y         (rsp_axis_y),
      .source_polygon (rsp_source_polygon),
      .empty_res      (rsp_empty_res),
      .overflowed     (rsp_overflowed)
   );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the polygon separating-axis test block. Vertex loads
// and evaluates come from a queue filled at time zero, with directed corner
// cases first and then random convex polygon pairs, noise sets, dropped loads
// and ignored items. A behavioral predictor tracks both vertex stores and
// computes the verdict of every accepted evaluate; the monitor compares each
// rsp transfer field by field. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import psat_pkg::*;

   localparam int          STORE_DEPTH  = MAX_VERTS_DEF;
   localparam int          ITEM_TARGET  = 1900;
   localparam int          STALL_LIMIT  = 20000;
   localparam int          DRAIN_CYCLES = 700;
   localparam int          HOLD_CYCLES  = 1500;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam real         PI           = 3.14159265358979;

   typedef struct packed {
      logic [15:0] y;
      logic [15:0] x;
   } vec_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] nx;
      logic [15:0] ny;
   } req_item_type;

   typedef struct packed {
      logic        separated;
      logic [31:0] depth;
      logic [15:0] axis_x;
      logic [15:0] axis_y;
      logic        source_polygon;
      logic        empty_res;
      logic        overflowed;
   } sat_verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_kind = '0;
   logic signed [15:0]  req_point_x = '0;
   logic signed [15:0]  req_point_y = '0;
   logic signed [15:0]  req_normal_x = '0;
   logic signed [15:0]  req_normal_y = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_separated;
   logic [31:0]         rsp_depth;
   logic signed [15:0]  rsp_axis_x;
   logic signed [15:0]  rsp_axis_y;
   logic                rsp_source_polygon;
   logic                rsp_empty_res;
   logic                rsp_overflowed;

   req_item_type     req_queue[$];
   req_item_type     shape_a[$];
   req_item_type     shape_b[$];
   sat_verdict_type  pending_verdicts[$];
   sat_verdict_type  want;
   req_item_type     next_req;

   vec_type       vert_store[2][STORE_DEPTH];
   vec_type       norm_store[2][STORE_DEPTH];
   int            held[2];
   bit            dropped_load;

   int            gen_count;
   int            items_total;
   int            sent_count;
   int            req_accepted;
   int            results_seen;
   int            fail_count;
   int            idle_cycles;
   int            hold_left;
   bit            hold_done;
   bit            req_taken;

   polygon_separating_axis_test i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_normal_x       (req_normal_x),
      .req_normal_y       (req_normal_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_separated      (rsp_separated),
      .rsp_depth          (rsp_depth),
      .rsp_axis_x         (rsp_axis_x),
      .rsp_axis_y         (rsp_axis_y),
      .rsp_source_polygon (rsp_source_polygon),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_overflowed     (rsp_overflowed)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor

   function automatic longint project(input vec_type v, input vec_type n);
      return longint'($signed(v.x)) * longint'($signed(n.x)) +
             longint'($signed(v.y)) * longint'($signed(n.y));
   endfunction

   function automatic longint extreme_projection(input int poly, input vec_type n,
                                                 input bit want_max);
      longint best;
      longint p;
      int     i;
      best = project(vert_store[poly][0], n);
      for (i = 1; i < held[poly]; i++) begin
         p = project(vert_store[poly][i], n);
         if (want_max ? (p > best) : (p < best)) best = p;
      end
      return best;
   endfunction

   function automatic sat_verdict_type predict_verdict();
      sat_verdict_type r;
      longint          gap;
      longint          best;
      bit              have;
      int              na;
      int              nb;
      int              own;
      int              k;
      vec_type         n;
      r    = '0;
      best = 0;
      have = 0;
      na   = held[0];
      nb   = held[1];
      if (na == 0 && nb == 0) begin
         r.empty_res = 1'b1;
      end else if (na == 0 || nb == 0) begin
         r.separated = 1'b1;
      end else begin
         for (k = 0; k < na + nb && !r.separated; k++) begin
            own = (k >= na) ? 1 : 0;
            n   = norm_store[own][own ? k - na : k];
            gap = extreme_projection(own, n, 1'b1) - extreme_projection(1 - own, n, 1'b0);
            if (gap < 0) begin
               r.separated = 1'b1;
            end else if (!have || gap < best) begin
               have             = 1'b1;
               best             = gap;
               r.axis_x         = n.x;
               r.axis_y         = n.y;
               r.source_polygon = own[0];
            end
         end
         if (r.separated) begin
            r.axis_x         = '0;
            r.axis_y         = '0;
            r.source_polygon = 1'b0;
         end else begin
            r.depth = (best > 64'sh00000000FFFFFFFF) ? 32'hFFFFFFFF : best[31:0];
         end
      end
      r.overflowed = dropped_load;
      return r;
   endfunction

   task automatic apply_request(input req_item_type it);
      int p;
      p = (it.kind == KIND_LOAD_B) ? 1 : 0;
      case (it.kind)
         KIND_LOAD_A, KIND_LOAD_B: begin
            if (held[p] < STORE_DEPTH) begin
               vert_store[p][held[p]] = {it.py, it.px};
               norm_store[p][held[p]] = {it.ny, it.nx};
               held[p]++;
            end else begin
               dropped_load = 1'b1;
            end
         end
         KIND_EVAL: begin
            pending_verdicts.push_back(predict_verdict());
            held[0]      = 0;
            held[1]      = 0;
            dropped_load = 1'b0;
         end
         default: ;
      endcase
   endtask

   // stimulus helpers

   function automatic req_item_type make_item(input logic [1:0] kind, input logic [15:0] x,
                                              input logic [15:0] y, input logic [15:0] nx,
                                              input logic [15:0] ny);
      req_item_type it;
      it.kind = kind;
      it.px   = x;
      it.py   = y;
      it.nx   = nx;
      it.ny   = ny;
      return it;
   endfunction

   task automatic add_request(input req_item_type it);
      req_queue.push_back(it);
      if (it.kind != KIND_UNUSED) gen_count++;
   endtask

   function automatic logic [15:0] round_clamp(input real v, input int lo, input int hi);
      int r;
      r = (v >= 0.0) ? $rtoi(v + 0.5) : $rtoi(v - 0.5);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r[15:0];
   endfunction

   function automatic logic [15:0] rand_coord();
      int v;
      case ($urandom_range(0, 7))
         0:       v = -32768;
         1:       v = 32767;
         2:       v = 0;
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return v[15:0];
   endfunction

   function automatic logic [15:0] rand_normal();
      int v;
      case ($urandom_range(0, 7))
         0:       v = -16384;
         1:       v = 16384;
         2:       v = 0;
         default: v = int'($urandom_range(0, 32768)) - 16384;
      endcase
      return v[15:0];
   endfunction

   function automatic int rand_count();
      int c;
      if ($urandom_range(0, 99) < 80) c = $urandom_range(3, 8);
      else c = $urandom_range(3, STORE_DEPTH);
      return c;
   endfunction

   // convex polygon, counterclockwise, with outward unit normals in Q1.14
   task automatic build_polygon(input bit to_b, input real cx, input real cy,
                                input real radius, input int count);
      real          corner_x[STORE_DEPTH];
      real          corner_y[STORE_DEPTH];
      real          rot;
      real          ang;
      real          ex;
      real          ey;
      real          len;
      int           i;
      int           j;
      req_item_type it;
      rot = $urandom_range(0, 359) * PI / 180.0;
      for (i = 0; i < count; i++) begin
         ang         = rot + 2.0 * PI * i / count;
         corner_x[i] = cx + radius * $cos(ang);
         corner_y[i] = cy + radius * $sin(ang);
      end
      for (i = 0; i < count; i++) begin
         j   = (i + 1) % count;
         ex  = corner_x[j] - corner_x[i];
         ey  = corner_y[j] - corner_y[i];
         len = $sqrt(ex * ex + ey * ey);
         if (len < 1.0e-9) begin
            ex  = 0.0;
            ey  = -1.0;
            len = 1.0;
         end
         it = make_item(to_b ? KIND_LOAD_B : KIND_LOAD_A,
                        round_clamp(corner_x[i], -32768, 32767),
                        round_clamp(corner_y[i], -32768, 32767),
                        round_clamp(ey / len * 16384.0, -16384, 16384),
                        round_clamp(-ex / len * 16384.0, -16384, 16384));
         if (to_b) shape_b.push_back(it);
         else shape_a.push_back(it);
      end
   endtask

   task automatic build_noise(input bit to_b, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (to_b) begin
            shape_b.push_back(make_item(KIND_LOAD_B, rand_coord(), rand_coord(),
                                        rand_normal(), rand_normal()));
         end else begin
            shape_a.push_back(make_item(KIND_LOAD_A, rand_coord(), rand_coord(),
                                        rand_normal(), rand_normal()));
         end
      end
   endtask

   task automatic issue_shapes(input bit with_noise, input bit with_eval);
      bit mixed;
      mixed = $urandom_range(0, 1);
      while (shape_a.size() != 0 || shape_b.size() != 0) begin
         if (with_noise && $urandom_range(0, 9) == 0) begin
            add_request(make_item(KIND_UNUSED, rand_coord(), rand_coord(),
                                  rand_normal(), rand_normal()));
         end
         if (shape_b.size() == 0 || (shape_a.size() != 0 && (!mixed || $urandom_range(0, 1))))
            add_request(shape_a.pop_front());
         else
            add_request(shape_b.pop_front());
      end
      if (with_eval) add_request(make_item(KIND_EVAL, rand_coord(), rand_coord(),
                                           rand_normal(), rand_normal()));
   endtask

   function automatic int noise_count();
      int sel;
      int c;
      sel = $urandom_range(0, 99);
      if (sel < 15) c = 0;
      else if (sel < 30) c = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 4);
      else c = $urandom_range(1, 8);
      return c;
   endfunction

   // stimulus and end of run

   initial begin
      real ra;
      real rb;
      real cxa;
      real cya;
      real spread;
      real phi;
      int  sel;

      gen_count = 0;

      // empty pair, then one polygon empty on either side
      add_request(make_item(KIND_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      add_request(make_item(KIND_LOAD_A, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000));
      add_request(make_item(KIND_EVAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_request(make_item(KIND_LOAD_B, 16'h8000, 16'h7FFF, 16'hC000, 16'h4000));
      add_request(make_item(KIND_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      // coordinate and normal extremes, largest overlap
      add_request(make_item(KIND_LOAD_A, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h4000));
      add_request(make_item(KIND_LOAD_A, 16'h8000, 16'h8000, 16'hC000, 16'hC000));
      add_request(make_item(KIND_LOAD_B, 16'h8000, 16'h8000, 16'hC000, 16'h0000));
      add_request(make_item(KIND_LOAD_B, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h4000));
      add_request(make_item(KIND_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      // identical squares, every gap ties
      add_request(make_item(KIND_LOAD_A, 16'd100, 16'd100, 16'h4000, 16'h0000));
      add_request(make_item(KIND_LOAD_B, 16'd100, 16'd100, 16'h4000, 16'h0000));
      add_request(make_item(KIND_LOAD_A, -16'sd100, 16'd100, 16'h0000, 16'h4000));
      add_request(make_item(KIND_LOAD_B, -16'sd100, 16'd100, 16'h0000, 16'h4000));
      add_request(make_item(KIND_LOAD_A, -16'sd100, -16'sd100, 16'hC000, 16'h0000));
      add_request(make_item(KIND_LOAD_B, -16'sd100, -16'sd100, 16'hC000, 16'h0000));
      add_request(make_item(KIND_LOAD_A, 16'd100, -16'sd100, 16'h0000, 16'hC000));
      add_request(make_item(KIND_UNUSED, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000));
      add_request(make_item(KIND_LOAD_B, 16'd100, -16'sd100, 16'h0000, 16'hC000));
      add_request(make_item(KIND_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

      while (gen_count < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            ra     = $urandom_range(200, 8000);
            rb     = $urandom_range(200, 8000);
            cxa    = int'($urandom_range(0, 24000)) - 12000;
            cya    = int'($urandom_range(0, 24000)) - 12000;
            spread = $urandom_range(0, 150) / 100.0 * (ra + rb);
            phi    = $urandom_range(0, 359) * PI / 180.0;
            build_polygon(1'b0, cxa, cya, ra, rand_count());
            build_polygon(1'b1, cxa + spread * $cos(phi), cya + spread * $sin(phi), rb,
                          rand_count());
            issue_shapes(1'b0, 1'b1);
         end else if (sel < 88) begin
            build_noise(1'b0, noise_count());
            build_noise(1'b1, noise_count());
            issue_shapes(1'b1, 1'b1);
         end else begin
            build_noise($urandom_range(0, 1), $urandom_range(1, 6));
            issue_shapes(1'b1, 1'b0);
         end
      end
      items_total = req_queue.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_accepted == items_total);
      wait (pending_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // driver of the req channel
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_queue.size() != 0 &&
             ((sent_count >= 600 && sent_count < 900) || $urandom_range(0, 99) >= 19)) begin
            next_req = req_queue.pop_front();
            sent_count++;
            req_valid    <= 1'b1;
            req_kind     <= next_req.kind;
            req_point_x  <= next_req.px;
            req_point_y  <= next_req.py;
            req_normal_x <= next_req.nx;
            req_normal_y <= next_req.ny;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp_ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 20) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (results_seen >= 40 && results_seen < 80) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 19);
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // monitor of both channels
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         apply_request(make_item(req_kind, req_point_x, req_point_y,
                                 req_normal_x, req_normal_y));
         req_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            $error("rsp transfer with no evaluate outstanding");
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("separated", want.separated, rsp_separated);
            check_field("depth", want.depth, rsp_depth);
            check_field("axis_x", want.axis_x, $unsigned(rsp_axis_x));
            check_field("axis_y", want.axis_y, $unsigned(rsp_axis_y));
            check_field("source_polygon", want.source_polygon, rsp_source_polygon);
            check_field("empty_res", want.empty_res, rsp_empty_res);
            check_field("overflowed", want.overflowed, rsp_overflowed);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
